// ===== design/kxo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the microcode program of the keystream XOR unit.
package kxo_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SECRET_W  = 64;
  localparam int unsigned NHEAD_W   = 64;
  localparam int unsigned NTAIL_W   = 32;
  localparam int unsigned NUM_SECRETS = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FNV_BYTES = (NHEAD_W + NTAIL_W + NUM_SECRETS * SECRET_W) / BYTE_W;
  localparam int unsigned FNV_VEC_W = FNV_BYTES * BYTE_W;
  localparam int unsigned FNV_CNT_W = $clog2(FNV_BYTES);
  localparam int unsigned STEP_W    = 3;

  localparam logic [WORD_W-1:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [WORD_W-1:0] FNV_PRIME  = 32'h01000193;
  localparam logic [WORD_W-1:0] MB_STEP    = 32'h6D2B79F5;
  localparam logic [WORD_W-1:0] MIX_OR1    = 32'd1;
  localparam logic [WORD_W-1:0] MIX_OR2    = 32'd61;
  localparam logic [FNV_CNT_W-1:0] FNV_LAST = FNV_CNT_W'(FNV_BYTES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SECRET0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET3 = 2'd3;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_FNV  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADD  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL1 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL2 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FIN  = 3'd5;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_FNV,
    OP_ADD,
    OP_MUL1,
    OP_MUL2,
    OP_FIN
  } op_t;

  typedef enum logic [1:0] {
    JMP_DISPATCH,  // on a transaction: target_a for a message start, else target_b
    JMP_LOOP,      // stay until the last hash byte, then target_a
    JMP_NEXT,      // always target_a
    JMP_OUT        // target_a once the output register is free
  } jmp_t;

  typedef struct packed {
    op_t               op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target_a;
    logic [STEP_W-1:0] target_b;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic fnv_last;
    logic out_free;
  } stat_t;

  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      STEP_WAIT: w = '{op: OP_WAIT, jmp: JMP_DISPATCH, target_a: STEP_FNV,  target_b: STEP_MUL1};
      STEP_FNV:  w = '{op: OP_FNV,  jmp: JMP_LOOP,     target_a: STEP_ADD,  target_b: STEP_FNV};
      STEP_ADD:  w = '{op: OP_ADD,  jmp: JMP_NEXT,     target_a: STEP_MUL1, target_b: STEP_MUL1};
      STEP_MUL1: w = '{op: OP_MUL1, jmp: JMP_NEXT,     target_a: STEP_MUL2, target_b: STEP_MUL2};
      STEP_MUL2: w = '{op: OP_MUL2, jmp: JMP_NEXT,     target_a: STEP_FIN,  target_b: STEP_FIN};
      STEP_FIN:  w = '{op: OP_FIN,  jmp: JMP_OUT,      target_a: STEP_WAIT, target_b: STEP_FIN};
      default:   w = '{op: OP_WAIT, jmp: JMP_NEXT,     target_a: STEP_WAIT, target_b: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/kxo_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message bytes in and transformed bytes out.
interface kxo_in_if;
  logic                          valid;
  logic                          ready;
  logic [kxo_pkg::BYTE_W-1:0]    data_byte;
  logic                          start_of_message;
  logic [kxo_pkg::NHEAD_W-1:0]   nonce_head;
  logic [kxo_pkg::NTAIL_W-1:0]   nonce_tail;

  modport source(output valid, data_byte, start_of_message, nonce_head, nonce_tail,
                 input ready);
  modport sink(input valid, data_byte, start_of_message, nonce_head, nonce_tail,
               output ready);
endinterface

interface kxo_out_if;
  logic                       valid;
  logic                       ready;
  logic [kxo_pkg::BYTE_W-1:0] out_byte;

  modport source(output valid, out_byte, input ready);
  modport sink(input valid, out_byte, output ready);
endinterface

// ===== design/kxo_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program table and conditional jumps.
module kxo_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  kxo_pkg::stat_t stat,
  output kxo_pkg::ctrl_t ctrl
);

  logic [kxo_pkg::STEP_W-1:0] step_r;
  logic [kxo_pkg::STEP_W-1:0] step_nxt;

  assign ctrl = kxo_pkg::rom_word(step_r);

  always_comb begin
    step_nxt = step_r;
    unique case (ctrl.jmp)
      kxo_pkg::JMP_DISPATCH: begin
        if (stat.accept) begin
          step_nxt = stat.start ? ctrl.target_a : ctrl.target_b;
        end
      end
      kxo_pkg::JMP_LOOP: begin
        step_nxt = stat.fnv_last ? ctrl.target_a : ctrl.target_b;
      end
      kxo_pkg::JMP_NEXT: begin
        step_nxt = ctrl.target_a;
      end
      kxo_pkg::JMP_OUT: begin
        step_nxt = stat.out_free ? ctrl.target_a : ctrl.target_b;
      end
      default: begin
        step_nxt = kxo_pkg::STEP_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= kxo_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/keystream_xor_obfuscator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the keystream XOR unit: configuration, datapath and output register.
//
// Each transaction on the input channel carries one message byte; the unit returns that
// byte XORed with the next keystream byte, so the same stream both scrambles and restores
// a message. For a byte without start_of_message the increment happens at acceptance,
// then two mix multiplications run on one shared 32x32 multiplier and a final fold
// follows. For a byte with start_of_message the seed is first hashed (FNV-1a) over the
// 12 nonce bytes and the 32 secret bytes at one byte per cycle on the same multiplier,
// then incremented. Results sit in an output register, so the next byte is accepted while
// an earlier result waits to be taken; the input is ready only between bytes, and the unit
// holds off in its final step while a new result is ready and that register is still full.
// Secret registers are written through cfg_we/cfg_index/cfg_wdata and take effect at the
// next message start.
module keystream_xor_obfuscator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kxo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kxo_pkg::SECRET_W-1:0]     cfg_wdata,
  kxo_in_if.sink                           in_ch,
  kxo_out_if.source                        out_ch
);

  kxo_pkg::ctrl_t ctrl;
  kxo_pkg::stat_t stat;

  logic [kxo_pkg::SECRET_W-1:0]  secret0_r, secret1_r, secret2_r, secret3_r;
  logic [kxo_pkg::WORD_W-1:0]    seed_r, seed_nxt;
  logic [kxo_pkg::WORD_W-1:0]    t_r, t_nxt;
  logic [kxo_pkg::WORD_W-1:0]    p_r, p_nxt;
  logic [kxo_pkg::BYTE_W-1:0]    data_r;
  logic [kxo_pkg::FNV_VEC_W-1:0] hash_sr_r, hash_sr_nxt;
  logic [kxo_pkg::FNV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [kxo_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;

  logic [kxo_pkg::WORD_W-1:0]    mul_a, mul_b, mul_p;
  logic [kxo_pkg::WORD_W-1:0]    t2;
  logic [kxo_pkg::BYTE_W-1:0]    ks;
  logic                          accept;

  kxo_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign in_ch.ready   = (ctrl.op == kxo_pkg::OP_WAIT);
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  assign stat.accept   = accept;
  assign stat.start    = in_ch.start_of_message;
  assign stat.fnv_last = (cnt_r == kxo_pkg::FNV_LAST);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  // Secret registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret0_r <= '0;
      secret1_r <= '0;
      secret2_r <= '0;
      secret3_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kxo_pkg::REG_SECRET0: secret0_r <= cfg_wdata;
        kxo_pkg::REG_SECRET1: secret1_r <= cfg_wdata;
        kxo_pkg::REG_SECRET2: secret2_r <= cfg_wdata;
        kxo_pkg::REG_SECRET3: secret3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One shared multiplier; its operands follow the current micro-op.
  always_comb begin
    unique case (ctrl.op)
      kxo_pkg::OP_FNV: begin
        mul_a = seed_r ^ {{(kxo_pkg::WORD_W - kxo_pkg::BYTE_W){1'b0}},
                          hash_sr_r[kxo_pkg::BYTE_W-1:0]};
        mul_b = kxo_pkg::FNV_PRIME;
      end
      kxo_pkg::OP_MUL1: begin
        mul_a = seed_r ^ (seed_r >> 15);
        mul_b = seed_r | kxo_pkg::MIX_OR1;
      end
      default: begin
        mul_a = t_r ^ (t_r >> 7);
        mul_b = t_r | kxo_pkg::MIX_OR2;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign t2    = t_r ^ (t_r + p_r);
  // Byte 1 of t2 ^ (t2 >> 14).
  assign ks    = t2[15:8] ^ t2[29:22];

  always_comb begin
    seed_nxt      = seed_r;
    t_nxt         = t_r;
    p_nxt         = p_r;
    hash_sr_nxt   = hash_sr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    unique case (ctrl.op)
      kxo_pkg::OP_WAIT: begin
        if (accept) begin
          seed_nxt    = in_ch.start_of_message ? kxo_pkg::FNV_OFFSET
                                               : seed_r + kxo_pkg::MB_STEP;
          hash_sr_nxt = {secret3_r, secret2_r, secret1_r, secret0_r,
                         in_ch.nonce_tail, in_ch.nonce_head};
          cnt_nxt     = '0;
        end
      end
      kxo_pkg::OP_FNV: begin
        seed_nxt    = mul_p;
        hash_sr_nxt = hash_sr_r >> kxo_pkg::BYTE_W;
        cnt_nxt     = cnt_r + 1'b1;
      end
      kxo_pkg::OP_ADD: begin
        seed_nxt = seed_r + kxo_pkg::MB_STEP;
      end
      kxo_pkg::OP_MUL1: begin
        t_nxt = mul_p;
      end
      kxo_pkg::OP_MUL2: begin
        p_nxt = mul_p;
      end
      kxo_pkg::OP_FIN: begin
        if (stat.out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ks;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    p_r        <= p_nxt;
    hash_sr_r  <= hash_sr_nxt;
    out_byte_r <= out_byte_nxt;
    if (accept) begin
      data_r <= in_ch.data_byte;
    end
  end

  // A continuing byte passes through the mix steps to the final fold without a stall.
  a_cont_timing: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.start_of_message |-> ##3 (ctrl.op == kxo_pkg::OP_FIN))
    else $error("continuing byte did not reach the final step on time");

  // A message start begins hashing from the first byte.
  a_start_hash: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.start_of_message |=> (ctrl.op == kxo_pkg::OP_FNV) && (cnt_r == '0))
    else $error("hash pass did not start at byte zero");

  // The hash loop leaves right after its last byte.
  a_hash_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == kxo_pkg::OP_FNV) && stat.fnv_last |=> (ctrl.op == kxo_pkg::OP_ADD))
    else $error("hash loop did not exit after the last byte");

  // A new result only appears from the final step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == kxo_pkg::OP_FIN))
    else $error("result appeared outside the final step");

endmodule

// ===== dv/keystream_xor_obfuscator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the keystream XOR unit with a built-in keystream predictor.
module keystream_xor_obfuscator_unit_tb;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 175;

  typedef struct packed {
    logic [kxo_pkg::BYTE_W-1:0]  data_byte;
    logic                        start_of_message;
    logic [kxo_pkg::NHEAD_W-1:0] nonce_head;
    logic [kxo_pkg::NTAIL_W-1:0] nonce_tail;
  } msg_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [kxo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kxo_pkg::SECRET_W-1:0] cfg_wdata;

  kxo_in_if  in_ch();
  kxo_out_if out_ch();

  keystream_xor_obfuscator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  msg_item_t pending_items[$];
  logic [kxo_pkg::BYTE_W-1:0] expected_bytes[$];

  // Predictor state: secret words as the block holds them and the running generator state.
  logic [kxo_pkg::SECRET_W-1:0] secret_copy[kxo_pkg::NUM_SECRETS];
  logic [kxo_pkg::WORD_W-1:0] stream_state;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic rx_hold_req;
  logic rx_hold;
  logic in_taken;
  msg_item_t drv_item;
  int unsigned fail_cnt;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [kxo_pkg::WORD_W-1:0] fnv_seed(
      input logic [kxo_pkg::NHEAD_W-1:0] head,
      input logic [kxo_pkg::NTAIL_W-1:0] tail);
    logic [kxo_pkg::WORD_W-1:0] h;
    h = kxo_pkg::FNV_OFFSET;
    for (int i = 0; i < kxo_pkg::NHEAD_W / kxo_pkg::BYTE_W; i++) begin
      h = (h ^ {24'd0, head[i*kxo_pkg::BYTE_W +: kxo_pkg::BYTE_W]}) * kxo_pkg::FNV_PRIME;
    end
    for (int i = 0; i < kxo_pkg::NTAIL_W / kxo_pkg::BYTE_W; i++) begin
      h = (h ^ {24'd0, tail[i*kxo_pkg::BYTE_W +: kxo_pkg::BYTE_W]}) * kxo_pkg::FNV_PRIME;
    end
    for (int k = 0; k < kxo_pkg::NUM_SECRETS; k++) begin
      for (int i = 0; i < kxo_pkg::SECRET_W / kxo_pkg::BYTE_W; i++) begin
        h = (h ^ {24'd0, secret_copy[k][i*kxo_pkg::BYTE_W +: kxo_pkg::BYTE_W]})
            * kxo_pkg::FNV_PRIME;
      end
    end
    return h;
  endfunction

  function automatic logic [kxo_pkg::WORD_W-1:0] mulberry_mix(
      input logic [kxo_pkg::WORD_W-1:0] s);
    logic [kxo_pkg::WORD_W-1:0] t;
    t = s;
    t = (t ^ (t >> 15)) * (t | kxo_pkg::MIX_OR1);
    t = t ^ (t + (t ^ (t >> 7)) * (t | kxo_pkg::MIX_OR2));
    return t ^ (t >> 14);
  endfunction

  task automatic predict_obfuscated(input msg_item_t it);
    logic [kxo_pkg::WORD_W-1:0] mixed;
    if (it.start_of_message) begin
      stream_state = fnv_seed(it.nonce_head, it.nonce_tail);
    end
    stream_state = stream_state + kxo_pkg::MB_STEP;
    mixed = mulberry_mix(stream_state);
    expected_bytes.push_back(it.data_byte ^ mixed[15:8]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic msg_item_t make_item(input logic [kxo_pkg::BYTE_W-1:0] data,
                                          input logic som,
                                          input logic [kxo_pkg::NHEAD_W-1:0] head,
                                          input logic [kxo_pkg::NTAIL_W-1:0] tail);
    msg_item_t it;
    it.data_byte = data;
    it.start_of_message = som;
    it.nonce_head = head;
    it.nonce_tail = tail;
    return it;
  endfunction

  // Nonce fields on continuation bytes are random on purpose; the block must ignore them.
  function automatic msg_item_t random_item(input logic som);
    return make_item(kxo_pkg::BYTE_W'($urandom_range(255)), som, rand64(), $urandom());
  endfunction

  // Input monitor, predictor and output checker.
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_we === 1'b1) begin
        secret_copy[cfg_index] = cfg_wdata;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte arrived with no transaction outstanding: actual %02h",
                 out_ch.out_byte);
          fail_cnt++;
        end else begin
          logic [kxo_pkg::BYTE_W-1:0] want;
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want, out_ch.out_byte);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        predict_obfuscated(make_item(in_ch.data_byte, in_ch.start_of_message,
                                     in_ch.nonce_head, in_ch.nonce_tail));
      end
      in_taken <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    end
  end

  // Sender: holds the current transaction until it is taken, then maybe idles.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= drv_item.data_byte;
        in_ch.start_of_message <= drv_item.start_of_message;
        in_ch.nonce_head <= drv_item.nonce_head;
        in_ch.nonce_tail <= drv_item.nonce_tail;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the output register fills and the input stalls.
  initial begin
    rx_hold = 1'b0;
    wait (rx_hold_req);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || rst_n !== 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_secret(input logic [kxo_pkg::CFG_IDX_W-1:0] idx,
                              input logic [kxo_pkg::SECRET_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_secrets(input logic [kxo_pkg::SECRET_W-1:0] w0,
                                 input logic [kxo_pkg::SECRET_W-1:0] w1,
                                 input logic [kxo_pkg::SECRET_W-1:0] w2,
                                 input logic [kxo_pkg::SECRET_W-1:0] w3);
    write_secret(kxo_pkg::REG_SECRET0, w0);
    write_secret(kxo_pkg::REG_SECRET1, w1);
    write_secret(kxo_pkg::REG_SECRET2, w2);
    write_secret(kxo_pkg::REG_SECRET3, w3);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  // Mostly well-formed messages with random content, with some stray continuation bytes.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    // Continue the previous message across the register update before any restart.
    pending_items.push_back(random_item(1'b0));
    pending_items.push_back(random_item(1'b0));
    queued = 2;
    while (queued < count) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
        pending_items.push_back(random_item(1'b1));
        queued++;
        repeat (len) begin
          pending_items.push_back(random_item(1'b0));
          queued++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          pending_items.push_back(random_item(1'b0));
          queued++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = kxo_pkg::REG_SECRET0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_message = 1'b0;
    in_ch.nonce_head = '0;
    in_ch.nonce_tail = '0;
    out_ch.ready = 1'b0;
    rx_hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_cnt = 0;
    stream_state = '0;
    for (int k = 0; k < kxo_pkg::NUM_SECRETS; k++) begin
      secret_copy[k] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bytes before any start run from the zero reset state, with nonces ignored.
    pending_items.push_back(make_item(8'h00, 1'b0, '0, '0));
    pending_items.push_back(make_item(8'hff, 1'b0, '1, '1));
    pending_items.push_back(make_item(8'h5a, 1'b0, 64'h0123456789abcdef, 32'h89abcdef));
    pending_items.push_back(make_item(8'h00, 1'b1, '0, '0));
    pending_items.push_back(make_item(8'hff, 1'b0, '1, '1));
    pending_items.push_back(make_item(8'h80, 1'b0, '0, '0));
    pending_items.push_back(make_item(8'hff, 1'b1, '1, '1));
    pending_items.push_back(make_item(8'h01, 1'b0, '0, '0));
    pending_items.push_back(make_item(8'ha5, 1'b1, {32{2'b10}}, {16{2'b10}}));
    pending_items.push_back(make_item(8'h5a, 1'b1, {32{2'b01}}, {16{2'b01}}));
    pending_items.push_back(make_item(8'h7f, 1'b0, {32{2'b10}}, {16{2'b10}}));
    pending_items.push_back(make_item(8'hff, 1'b1, '0, '1));
    pending_items.push_back(make_item(8'h00, 1'b1, '1, '0));
    pending_items.push_back(make_item(8'h3c, 1'b0, '0, '0));
    pending_items.push_back(make_item(8'hc3, 1'b0, '1, '1));
    drain();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: program_secrets('1, '1, '1, '1);
        2: program_secrets('0, '0, '0, '0);
        3: program_secrets({32{2'b10}}, {32{2'b01}}, '1, '0);
        default: program_secrets(rand64(), rand64(), rand64(), rand64());
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct = 7;
          recv_stall_pct = 7;
        end
      endcase
      queue_random_traffic(PHASE_ITEMS);
      if (p == 4) begin
        rx_hold_req = 1'b1;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("out_byte: %0d transactions never produced a result", expected_bytes.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
